>>> rtl/csc_pkg.sv
package csc_pkg;

    localparam int BUTTON_COUNT = 4;

    // Mode codes
    localparam logic [2:0] MODE_WAIT  = 3'd0;
    localparam logic [2:0] MODE_COUNT = 3'd1;
    localparam logic [2:0] MODE_BUZZ  = 3'd2;
    localparam logic [2:0] MODE_RUN   = 3'd3;
    localparam logic [2:0] MODE_STOP  = 3'd4;
    localparam logic [2:0] MODE_FIN   = 3'd5;

    // Button slots in the lockout array
    localparam int KEY_START = 0;
    localparam int KEY_STOP  = 1;
    localparam int KEY_BACK  = 2;
    localparam int KEY_CLEAR = 3;

    // Configuration register indexes
    localparam logic [2:0] CFG_COUNTDOWN_SECONDS = 3'd0;
    localparam logic [2:0] CFG_START_BUZZ_MS     = 3'd1;
    localparam logic [2:0] CFG_STOP_BUZZ_MS      = 3'd2;
    localparam logic [2:0] CFG_REMOTE_WINDOW_MS  = 3'd3;
    localparam logic [2:0] CFG_BUTTON_LOCKOUT_MS = 3'd4;

    localparam int CFG_DATA_W = 14;

    localparam logic [3:0]  RST_COUNTDOWN_SECONDS = 4'd3;
    localparam logic [13:0] RST_START_BUZZ_MS     = 14'd800;
    localparam logic [13:0] RST_STOP_BUZZ_MS      = 14'd1000;
    localparam logic [13:0] RST_REMOTE_WINDOW_MS  = 14'd3000;
    localparam logic [7:0]  RST_BUTTON_LOCKOUT_MS = 8'd200;

    localparam logic [13:0] PHASE_MAX    = 14'd16383;
    localparam logic [7:0]  LOCKOUT_MAX  = 8'd255;
    localparam logic [9:0]  MS_PER_SEC   = 10'd1000;
    localparam logic [3:0]  MS_PER_HUND  = 4'd10;
    localparam logic [6:0]  HUND_PER_SEC = 7'd100;
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
    localparam logic [6:0]  MIN_LIMIT    = 7'd99;
    localparam logic [5:0]  SEC_LIMIT    = 6'd59;
    localparam logic [6:0]  HUND_LIMIT   = 7'd99;

    typedef struct packed {
        logic start_level;
        logic stop_level;
        logic back_level;
        logic clear_level;
        logic remote_valid;
        logic remote_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0] mode;
        logic       buzz_level;
        logic [6:0] minutes;
        logic [5:0] seconds;
        logic [6:0] hundredths;
        logic [3:0] countdown_left;
        logic       ack_pulse;
        logic       window_open;
    } t_out_item;

    typedef struct packed {
        logic [3:0]  countdown_seconds;
        logic [13:0] start_buzz_ms;
        logic [13:0] stop_buzz_ms;
        logic [13:0] remote_window_ms;
        logic [7:0]  button_lockout_ms;
    } t_cfg;

    typedef struct packed {
        logic [3:0] ms;
        logic [6:0] hund;
        logic [5:0] sec;
        logic [6:0] min;
    } t_watch;

    typedef struct packed {
        logic [2:0]                        mode;
        logic [13:0]                       phase_timer;
        logic                              buzzer;
        t_watch                            watch;
        logic                              remote_latched;
        logic [13:0]                       window_timer;
        logic                              window_active;
        logic [BUTTON_COUNT-1:0][7:0]      lockout;
    } t_state;

endpackage

>>> rtl/csc_step.sv
module csc_step import csc_pkg::*; (
    input  t_state    i_state,
    input  t_cfg      i_cfg,
    input  t_in_item  i_item,
    output t_state    o_state,
    output t_out_item o_item
);

    // Advance the stopwatch by one ms, holding at 99:59.99.
    function automatic t_watch watch_tick(input t_watch w);
        t_watch r;
        r = w;
        if (!(w.min >= MIN_LIMIT && w.sec >= SEC_LIMIT && w.hund >= HUND_LIMIT)) begin
            if (w.ms + 4'd1 < MS_PER_HUND) begin
                r.ms = w.ms + 4'd1;
            end else begin
                r.ms = '0;
                if (w.hund + 7'd1 < HUND_PER_SEC) begin
                    r.hund = w.hund + 7'd1;
                end else begin
                    r.hund = '0;
                    if (w.sec + 6'd1 < SEC_PER_MIN) begin
                        r.sec = w.sec + 6'd1;
                    end else begin
                        r.sec = '0;
                        r.min = w.min + 7'd1;
                    end
                end
            end
        end
        return r;
    endfunction

    // Whole seconds in a ms count below 16000: independent compares.
    function automatic logic [3:0] whole_secs(input logic [13:0] d);
        logic [3:0] r;
        r = '0;
        for (int k = 1; k < 16; k++) begin
            if ({2'b00, d} >= 16'(k * 1000)) begin
                r = 4'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [13:0] phase_inc(input logic [13:0] p);
        return (p < PHASE_MAX) ? p + 14'd1 : p;
    endfunction

    t_state                  s;
    logic [BUTTON_COUNT-1:0] levels;
    logic [BUTTON_COUNT-1:0] ok;
    logic [BUTTON_COUNT-1:0] take;
    logic                    ack;
    logic [3:0]              left;
    logic [13:0]             total;
    logic                    remote_stop;

    // at most 15 * 1000, fits the 14-bit phase timer range
    assign total = {10'd0, i_cfg.countdown_seconds} * {4'd0, MS_PER_SEC};

    always_comb begin
        levels[KEY_START] = i_item.start_level;
        levels[KEY_STOP]  = i_item.stop_level;
        levels[KEY_BACK]  = i_item.back_level;
        levels[KEY_CLEAR] = i_item.clear_level;
    end

    always_comb begin
        for (int b = 0; b < BUTTON_COUNT; b++) begin
            ok[b] = levels[b] && (i_state.lockout[b] >= i_cfg.button_lockout_ms);
        end
    end

    always_comb begin
        s           = i_state;
        take        = '0;
        ack         = 1'b0;
        left        = '0;
        remote_stop = 1'b0;

        // Remote message first
        if (i_item.remote_valid) begin
            s.remote_latched = i_item.remote_value;
            if (i_item.remote_value && !i_state.window_active) begin
                s.window_active = 1'b1;
                s.window_timer  = '0;
                ack             = 1'b1;
            end
        end

        case (i_state.mode)
            MODE_COUNT: begin
                s.phase_timer = phase_inc(i_state.phase_timer);
                if (s.phase_timer >= total) begin
                    s.phase_timer = '0;
                    s.buzzer      = 1'b1;
                    s.mode        = MODE_BUZZ;
                end else begin
                    left = whole_secs(total - s.phase_timer);
                end
            end
            MODE_BUZZ: begin
                s.phase_timer = phase_inc(i_state.phase_timer);
                if (s.phase_timer >= i_cfg.start_buzz_ms) begin
                    s.buzzer = 1'b0;
                    s.watch  = '0;
                    s.mode   = MODE_RUN;
                end
            end
            MODE_RUN: begin
                s.watch     = watch_tick(i_state.watch);
                remote_stop = s.remote_latched && s.window_active;
                // stop button is not polled while the remote stop holds
                take[KEY_STOP] = !remote_stop && ok[KEY_STOP];
                if (remote_stop || take[KEY_STOP]) begin
                    s.phase_timer = '0;
                    s.buzzer      = 1'b1;
                    s.mode        = MODE_STOP;
                end
                take[KEY_CLEAR] = ok[KEY_CLEAR];
                if (take[KEY_CLEAR]) begin
                    s.watch = '0;
                    s.mode  = MODE_FIN;
                end
            end
            MODE_STOP: begin
                s.phase_timer = phase_inc(i_state.phase_timer);
                if (s.phase_timer >= i_cfg.stop_buzz_ms) begin
                    s.buzzer = 1'b0;
                end
                take[KEY_BACK]  = ok[KEY_BACK];
                take[KEY_CLEAR] = ok[KEY_CLEAR];
                if (take[KEY_BACK]) begin
                    s.mode = MODE_WAIT;
                end
                if (take[KEY_CLEAR]) begin
                    s.watch = '0;
                    s.mode  = MODE_FIN;
                end
            end
            MODE_FIN: begin
                s.remote_latched = 1'b0;
                take[KEY_BACK]   = ok[KEY_BACK];
                take[KEY_CLEAR]  = ok[KEY_CLEAR];
                if (take[KEY_BACK]) begin
                    s.mode = MODE_WAIT;
                end
                if (take[KEY_CLEAR]) begin
                    s.watch = '0;
                end
            end
            default: begin
                take[KEY_START] = ok[KEY_START];
                if (take[KEY_START]) begin
                    s.phase_timer = '0;
                    s.mode        = MODE_COUNT;
                    left          = i_cfg.countdown_seconds;
                end
            end
        endcase

        if (s.mode != MODE_BUZZ && s.mode != MODE_STOP) begin
            s.buzzer = 1'b0;
        end

        for (int b = 0; b < BUTTON_COUNT; b++) begin
            if (take[b]) begin
                s.lockout[b] = '0;
            end else if (i_state.lockout[b] < LOCKOUT_MAX) begin
                s.lockout[b] = i_state.lockout[b] + 8'd1;
            end
        end

        if (s.window_active) begin
            if (s.window_timer >= i_cfg.remote_window_ms) begin
                s.window_active = 1'b0;
            end else begin
                s.window_timer = s.window_timer + 14'd1;
            end
        end
    end

    assign o_state = s;

    always_comb begin
        o_item.mode           = s.mode;
        o_item.buzz_level     = s.buzzer;
        o_item.minutes        = s.watch.min;
        o_item.seconds        = s.watch.sec;
        o_item.hundredths     = s.watch.hund;
        o_item.countdown_left = left;
        o_item.ack_pulse      = ack;
        o_item.window_open    = s.window_active;
    end

endmodule

>>> rtl/countdown_stopwatch_controller.sv
// Countdown stopwatch controller. Each input item is one millisecond tick
// carrying the four button levels and an optional remote stop message; each
// item yields exactly one result item with the mode, buzzer level, stopwatch
// time (saturating at 99:59.99), countdown seconds left, remote acknowledge
// pulse and window state after that tick. The block is a two-stage pipeline:
// an input register, then the whole tick update in one pass of combinational
// logic into the state and the result register. Throughput is one item per
// clock while the result side is ready. The configuration registers are
// plain write-only registers selected by index and should be written only
// while no item is in flight.
module countdown_stopwatch_controller import csc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    t_state    r_state;
    t_state    n_state;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;
    logic      advance;

    // The result stage frees when empty or being taken this cycle.
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    // Configuration registers; unused indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.countdown_seconds <= RST_COUNTDOWN_SECONDS;
            r_cfg.start_buzz_ms     <= RST_START_BUZZ_MS;
            r_cfg.stop_buzz_ms      <= RST_STOP_BUZZ_MS;
            r_cfg.remote_window_ms  <= RST_REMOTE_WINDOW_MS;
            r_cfg.button_lockout_ms <= RST_BUTTON_LOCKOUT_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COUNTDOWN_SECONDS: r_cfg.countdown_seconds <= i_cfg_data[3:0];
                CFG_START_BUZZ_MS:     r_cfg.start_buzz_ms     <= i_cfg_data[13:0];
                CFG_STOP_BUZZ_MS:      r_cfg.stop_buzz_ms      <= i_cfg_data[13:0];
                CFG_REMOTE_WINDOW_MS:  r_cfg.remote_window_ms  <= i_cfg_data[13:0];
                CFG_BUTTON_LOCKOUT_MS: r_cfg.button_lockout_ms <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    // One tick of the controller
    csc_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_item  (r_in_item),
        .o_state (n_state),
        .o_item  (n_out_item)
    );

    // Controller state moves only when the tick's result is captured.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (r_in_valid && advance) begin
            r_state <= n_state;
        end
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
